// File: rtl/rgb_to_yuv420_converter_defines.svh
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter - assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_DEFINES_SVH

// condition holds at every edge
`define R2Y_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger at one edge implies condition at the next
`define R2Y_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: rtl/r2y_pkg.sv
// ----------------------------------------------------------------------------
// r2y_pkg
// Shared widths, constants and register indexes of the RGB to YUV converter.
// ----------------------------------------------------------------------------
package r2y_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int SAMPLE_W    = 10;
	localparam int OUT_W       = 8;
	localparam int PAIR_W      = SAMPLE_W + 1;
	localparam int LINE_W      = 3 * PAIR_W;
	localparam int ROW_WIDTH_W = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 11;

	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

	// 16 fractional bits
	localparam logic [15:0] COEF_Y_R = 16'd19595;
	localparam logic [15:0] COEF_Y_G = 16'd38470;
	localparam logic [15:0] COEF_Y_B = 16'd7471;
	localparam logic [15:0] COEF_U_R = 16'd9642;   // negative term
	localparam logic [15:0] COEF_U_G = 16'd18931;  // negative term
	localparam logic [15:0] COEF_U_B = 16'd28574;
	localparam logic [15:0] COEF_V_R = 16'd40305;
	localparam logic [15:0] COEF_V_G = 16'd33750;  // negative term
	localparam logic [15:0] COEF_V_B = 16'd6554;   // negative term

	localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEPTH_MODE = 1'b0,
		REG_ROW_WIDTH  = 1'b1
	} cfg_reg_t;

endpackage

// File: rtl/r2y_pixel_if.sv
// ----------------------------------------------------------------------------
// r2y_pixel_if
// RGB pixel request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface r2y_pixel_if;
	logic                           valid;
	logic                           ready;
	logic [r2y_pkg::SAMPLE_W-1:0]   red;
	logic [r2y_pkg::SAMPLE_W-1:0]   green;
	logic [r2y_pkg::SAMPLE_W-1:0]   blue;
	logic                           frame_start;

	modport source (output valid, red, green, blue, frame_start, input ready);
	modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

// File: rtl/r2y_yuv_if.sv
// ----------------------------------------------------------------------------
// r2y_yuv_if
// Luma/chroma result request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface r2y_yuv_if;
	logic                        valid;
	logic                        ready;
	logic [r2y_pkg::OUT_W-1:0]   luma;
	logic                        chroma_valid;
	logic [r2y_pkg::OUT_W-1:0]   u_value;
	logic [r2y_pkg::OUT_W-1:0]   v_value;

	modport source (output valid, luma, chroma_valid, u_value, v_value, input ready);
	modport sink   (input valid, luma, chroma_valid, u_value, v_value, output ready);
endinterface

// File: rtl/r2y_ram.sv
// ----------------------------------------------------------------------------
// r2y_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module r2y_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rgb_to_yuv420_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// RGB pixels in raster order to 8-bit luma per pixel and 4:2:0 chroma.
// ----------------------------------------------------------------------------
// pixels: sink channel, one RGB request per pixel, frame_start on the first
//   pixel of a frame restarts row and column.
// yuv: source channel, one result per pixel: luma always, u/v with
//   chroma_valid on the odd-row, odd-column pixel of each 2x2 block.
// cfg_write/cfg_index/cfg_data: register writes; the user must write only while idle (not enforced).
// Throughput: one pixel per cycle while yuv.ready holds. The line store takes
//   one write and one read per cycle, and each pixel touches it at most once.
// Pipeline: line store read, multiply, luma sum, chroma sum, clip/output
//   register, in that order from accept to the result on yuv.
// Reset: row and column restart at zero, depth_mode 0, row_width 1024. The
//   line store is not cleared; an even row fills it before it is read.
// Stall: a full stage holds only while the one after it holds, so bubbles close
//   up and pixels keep being accepted until the whole pipeline is full.
// ----------------------------------------------------------------------------
`include "rgb_to_yuv420_converter_defines.svh"

module rgb_to_yuv420_converter #(
	parameter int MAX_WIDTH = r2y_pkg::MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [r2y_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [r2y_pkg::CFG_DATA_W-1:0]    cfg_data,
	r2y_pixel_if.sink                         pixels,
	r2y_yuv_if.source                         yuv
);

	localparam int SW         = r2y_pkg::SAMPLE_W;
	localparam int PW         = r2y_pkg::PAIR_W;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CMP_W      = (COL_W + 1 > r2y_pkg::ROW_WIDTH_W) ? COL_W + 1
	                                                                : r2y_pkg::ROW_WIDTH_W;
	localparam int MAX_EVEN   = MAX_WIDTH - (MAX_WIDTH % 2);

	function automatic logic [r2y_pkg::OUT_W-1:0] chroma_scale(
		input logic signed [29:0] acc,
		input logic               mode
	);
		logic signed [29:0] biased;
		logic signed [11:0] q;
		logic signed [11:0] qm;
		logic signed [12:0] off;
		biased = acc + (acc[29] ? 30'sd262143 : 30'sd0);
		q      = biased[29:18];
		qm     = mode ? (q >>> 2) : q;
		off    = {qm[11], qm} + 13'sd128;
		if (off < 13'sd0) begin
			return '0;
		end else if (off > 13'sd255) begin
			return r2y_pkg::OUT_MAX;
		end
		return off[7:0];
	endfunction

	// configuration
	logic                                depth_mode_q;
	logic [r2y_pkg::ROW_WIDTH_W-1:0]     row_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q <= 1'b0;
			row_width_q  <= r2y_pkg::ROW_WIDTH_RESET;
		end else if (cfg_write) begin
			case (r2y_pkg::cfg_reg_t'(cfg_index))
				r2y_pkg::REG_DEPTH_MODE: depth_mode_q <= cfg_data[0];
				r2y_pkg::REG_ROW_WIDTH:  row_width_q  <= cfg_data[r2y_pkg::ROW_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective width: clamp to 2..MAX_WIDTH, even
	logic [CMP_W-1:0] width_clamp;
	logic [CMP_W-1:0] width_eff;

	always_comb begin
		if (CMP_W'(row_width_q) > CMP_W'(MAX_EVEN)) begin
			width_clamp = CMP_W'(MAX_EVEN);
		end else if (CMP_W'(row_width_q) < CMP_W'(2)) begin
			width_clamp = CMP_W'(2);
		end else begin
			width_clamp = CMP_W'(row_width_q);
		end
		width_eff = {width_clamp[CMP_W-1:1], 1'b0};
	end

	// handshake and stage advance
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic adv1, adv2, adv3, adv4, adv_out;
	logic accept;

	assign adv_out      = !out_valid_q || yuv.ready;
	assign adv4         = !valid_s4 || adv_out;
	assign adv3         = !valid_s3 || adv4;
	assign adv2         = !valid_s2 || adv3;
	assign adv1         = !valid_s1 || adv2;
	assign pixels.ready = adv1;
	assign accept       = pixels.valid && adv1;

	// raster position
	logic [COL_W-1:0] column_q;
	logic             odd_row_q;
	logic [COL_W-1:0] col_cur;
	logic             odd_cur;
	logic [CMP_W-1:0] col_next;
	logic             wrap;

	always_comb begin
		col_cur = pixels.frame_start ? '0 : column_q;
		odd_cur = pixels.frame_start ? 1'b0 : odd_row_q;
		if (CMP_W'(col_cur) >= width_eff) begin
			col_cur = '0;
		end
		col_next = CMP_W'(col_cur) + CMP_W'(1);
		wrap     = col_next >= width_eff;
	end

	// left pixel of the current pair
	logic [SW-1:0] left_r_q, left_g_q, left_b_q;
	logic [PW-1:0] pair_r, pair_g, pair_b;

	assign pair_r = {1'b0, left_r_q} + {1'b0, pixels.red};
	assign pair_g = {1'b0, left_g_q} + {1'b0, pixels.green};
	assign pair_b = {1'b0, left_b_q} + {1'b0, pixels.blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			odd_row_q <= 1'b0;
			left_r_q  <= '0;
			left_g_q  <= '0;
			left_b_q  <= '0;
		end else if (accept) begin
			column_q  <= wrap ? '0 : col_next[COL_W-1:0];
			odd_row_q <= wrap ? !odd_cur : odd_cur;
			if (!col_cur[0]) begin
				left_r_q <= pixels.red;
				left_g_q <= pixels.green;
				left_b_q <= pixels.blue;
			end
		end
	end

	// line store of even-row pair sums
	logic                      ram_we, ram_re;
	logic [ADDR_W-1:0]         ram_addr;
	logic [r2y_pkg::LINE_W-1:0] ram_rdata;

	assign ram_we   = accept && col_cur[0] && !odd_cur;
	assign ram_re   = accept && col_cur[0] && odd_cur;
	assign ram_addr = ADDR_W'(col_cur >> 1);

	r2y_ram #(
		.WIDTH (r2y_pkg::LINE_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata ({pair_b, pair_g, pair_r}),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// stage 1: samples, pair sums, line data arriving
	logic [SW-1:0] red_s1, green_s1, blue_s1;
	logic [PW-1:0] pair_r_s1, pair_g_s1, pair_b_s1;
	logic          chroma_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			red_s1    <= pixels.red;
			green_s1  <= pixels.green;
			blue_s1   <= pixels.blue;
			pair_r_s1 <= pair_r;
			pair_g_s1 <= pair_g;
			pair_b_s1 <= pair_b;
			chroma_s1 <= col_cur[0] && odd_cur;
		end
	end

	// stage 2: luma products, block sums
	logic [25:0] y_r_s2, y_g_s2, y_b_s2;
	logic [11:0] sum_r_s2, sum_g_s2, sum_b_s2;
	logic        chroma_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			y_r_s2    <= 26'(r2y_pkg::COEF_Y_R) * 26'(red_s1);
			y_g_s2    <= 26'(r2y_pkg::COEF_Y_G) * 26'(green_s1);
			y_b_s2    <= 26'(r2y_pkg::COEF_Y_B) * 26'(blue_s1);
			sum_r_s2  <= 12'(pair_r_s1) + 12'(ram_rdata[PW-1:0]);
			sum_g_s2  <= 12'(pair_g_s1) + 12'(ram_rdata[2*PW-1:PW]);
			sum_b_s2  <= 12'(pair_b_s1) + 12'(ram_rdata[3*PW-1:2*PW]);
			chroma_s2 <= chroma_s1;
		end
	end

	// stage 3: luma, chroma products
	logic [26:0]              y_sum;
	logic [10:0]              y_shift;
	logic [r2y_pkg::OUT_W-1:0] luma_s3;
	logic [27:0]              u_r_s3, u_g_s3, u_b_s3, v_r_s3, v_g_s3, v_b_s3;
	logic                     chroma_s3;

	assign y_sum   = 27'(y_r_s2) + 27'(y_g_s2) + 27'(y_b_s2);
	assign y_shift = depth_mode_q ? 11'(y_sum[26:18]) : y_sum[26:16];

	always_ff @(posedge clk) begin
		if (adv3) begin
			luma_s3   <= (y_shift > 11'd255) ? r2y_pkg::OUT_MAX : y_shift[7:0];
			u_r_s3    <= 28'(r2y_pkg::COEF_U_R) * 28'(sum_r_s2);
			u_g_s3    <= 28'(r2y_pkg::COEF_U_G) * 28'(sum_g_s2);
			u_b_s3    <= 28'(r2y_pkg::COEF_U_B) * 28'(sum_b_s2);
			v_r_s3    <= 28'(r2y_pkg::COEF_V_R) * 28'(sum_r_s2);
			v_g_s3    <= 28'(r2y_pkg::COEF_V_G) * 28'(sum_g_s2);
			v_b_s3    <= 28'(r2y_pkg::COEF_V_B) * 28'(sum_b_s2);
			chroma_s3 <= chroma_s2;
		end
	end

	// stage 4: signed chroma sums
	logic [r2y_pkg::OUT_W-1:0] luma_s4;
	logic signed [29:0]       u_acc_s4, v_acc_s4;
	logic                     chroma_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			luma_s4   <= luma_s3;
			u_acc_s4  <= $signed({2'b00, u_b_s3}) - $signed({2'b00, u_r_s3})
			             - $signed({2'b00, u_g_s3});
			v_acc_s4  <= $signed({2'b00, v_r_s3}) - $signed({2'b00, v_g_s3})
			             - $signed({2'b00, v_b_s3});
			chroma_s4 <= chroma_s3;
		end
	end

	// output register
	logic [r2y_pkg::OUT_W-1:0] luma_q, u_q, v_q;
	logic                     chroma_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			luma_q   <= luma_s4;
			chroma_q <= chroma_s4;
			u_q      <= chroma_s4 ? chroma_scale(u_acc_s4, depth_mode_q) : '0;
			v_q      <= chroma_s4 ? chroma_scale(v_acc_s4, depth_mode_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= accept;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv_out) out_valid_q <= valid_s4;
		end
	end

	assign yuv.valid        = out_valid_q;
	assign yuv.luma         = luma_q;
	assign yuv.chroma_valid = chroma_q;
	assign yuv.u_value      = u_q;
	assign yuv.v_value      = v_q;

	`R2Y_ASSERT_ALWAYS(a_line_one_access, !(ram_we && ram_re), "line store read and write together")
	`R2Y_ASSERT_NEXT(a_frame_restart, accept && pixels.frame_start, (column_q == COL_W'(1)) && !odd_row_q, "frame start did not restart raster position")
	`R2Y_ASSERT_NEXT(a_chroma_issue, ram_re, valid_s1 && chroma_s1, "line read without chroma item in stage 1")

endmodule
